// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int SIZE_W  = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 32;
	localparam int EVICT_W = 5;

	localparam logic [SIZE_W-1:0]  CAP_RESET = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_NEW = 32'd1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_GET    = 2'd1,
		OP_EXISTS = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   item_size;
		logic [VALUE_W-1:0]  item_value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic                hit;
		logic [VALUE_W-1:0]  read_value;
		logic [SIZE_W-1:0]   free_space;
		logic [EVICT_W-1:0]  evicted_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   size;
		logic [VALUE_W-1:0]  value;
		logic [COUNT_W-1:0]  count;
	} entry_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_LOOKUP,
		FSM_DECIDE,
		FSM_CHECK,
		FSM_VICTIM,
		FSM_VFREE,
		FSM_FREESCAN,
		FSM_PLACE,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic    load;
		logic    scan_start;
		logic    clear_all;
		logic    free_match;
		logic    free_victim;
		logic    place;
		logic    bump;
		logic    emit;
		status_t status;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic too_large;
		logic need_evict;
		logic any_valid;
		logic scan_done;
		logic rsp_free;
	} ctl_sts_t;

endpackage

// ===== rtl/core/lfu_ctrl.sv =====
module lfu_ctrl
	import lfu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	fsm_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (req_valid) state_nxt = FSM_LOOKUP;
			end
			FSM_LOOKUP: begin
				if (sts.scan_done) state_nxt = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (sts.op == OP_ADD && !sts.too_large) state_nxt = FSM_CHECK;
				else state_nxt = FSM_EMIT;
			end
			FSM_CHECK: begin
				if (sts.need_evict && sts.any_valid) state_nxt = FSM_VICTIM;
				else state_nxt = FSM_FREESCAN;
			end
			FSM_VICTIM: begin
				if (sts.scan_done) state_nxt = FSM_VFREE;
			end
			FSM_VFREE:    state_nxt = FSM_CHECK;
			FSM_FREESCAN: begin
				if (sts.scan_done) state_nxt = FSM_PLACE;
			end
			FSM_PLACE:    state_nxt = FSM_EMIT;
			FSM_EMIT: begin
				if (sts.rsp_free) state_nxt = FSM_IDLE;
			end
			default:      state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		req_stall = (state_q != FSM_IDLE);
		case (state_q)
			FSM_IDLE: begin
				cmd.load       = req_valid;
				cmd.scan_start = req_valid;
			end
			FSM_DECIDE: begin
				case (sts.op)
					OP_ADD: begin
						cmd.clear_all  = sts.too_large;
						cmd.free_match = !sts.too_large && sts.hit;
					end
					OP_GET:    cmd.bump       = sts.hit;
					OP_REMOVE: cmd.free_match = sts.hit;
					default:   ;
				endcase
			end
			FSM_CHECK:  cmd.scan_start  = 1'b1;
			FSM_VFREE:  cmd.free_victim = 1'b1;
			FSM_PLACE:  cmd.place       = 1'b1;
			FSM_EMIT: begin
				cmd.emit = sts.rsp_free;
				if (sts.op == OP_ADD) cmd.status = sts.too_large ? ST_TOO_LARGE : ST_OK;
				else cmd.status = sts.hit ? ST_OK : ST_NOT_FOUND;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/lfu_dpath.sv =====
module lfu_dpath
	import lfu_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req_data,
	output rsp_t              rsp_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  ctl_cmd_t          cmd,
	output ctl_sts_t          sts
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	entry_t mem [ENTRIES];

	req_t               req_q;
	logic [SIZE_W-1:0]  cap_q;
	logic [SIZE_W-1:0]  space_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      nvalid_q;
	logic [EVICT_W-1:0] evicted_q;

	logic          scan_run_q;
	logic [IW-1:0] scan_addr_q;
	logic          vld_s1;
	logic          last_s1;
	logic [IW-1:0] idx_s1;
	entry_t        rdata_s1;

	logic               found_q;
	logic [IW-1:0]      midx_q;
	entry_t             ment_q;
	logic               vfound_q;
	logic [IW-1:0]      vidx_q;
	logic [COUNT_W-1:0] vcount_q;
	logic [SIZE_W-1:0]  vsize_q;
	logic               ffound_q;
	logic [IW-1:0]      fidx_q;

	logic   rsp_valid_q;
	rsp_t   rsp_q;
	logic   rsp_free;
	logic   ent_v;
	entry_t wr_ent;

	assign ent_v    = valid_q[idx_s1];
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Slot walk: one read per cycle, read data registered for the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q  <= 1'b0;
			scan_addr_q <= '0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= scan_run_q;
			if (cmd.scan_start) begin
				scan_run_q  <= 1'b1;
				scan_addr_q <= '0;
			end else if (scan_run_q) begin
				if (scan_addr_q == LAST_IDX) scan_run_q <= 1'b0;
				scan_addr_q <= scan_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (scan_addr_q == LAST_IDX);
		idx_s1  <= scan_addr_q;
	end

	always_comb begin
		wr_ent = ment_q;
		if (cmd.place) begin
			wr_ent.key   = req_q.key;
			wr_ent.size  = req_q.item_size;
			wr_ent.value = req_q.item_value;
			wr_ent.count = COUNT_NEW;
		end else if (ment_q.count != COUNT_MAX) begin
			wr_ent.count = ment_q.count + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place) mem[fidx_q] <= wr_ent;
		else if (cmd.bump) mem[midx_q] <= wr_ent;
		if (scan_run_q) rdata_s1 <= mem[scan_addr_q];
	end

	// Key match, lowest-count victim and first free slot trackers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			vfound_q <= 1'b0;
			ffound_q <= 1'b0;
		end else begin
			if (cmd.load) found_q <= 1'b0;
			if (cmd.scan_start) begin
				vfound_q <= 1'b0;
				ffound_q <= 1'b0;
			end else if (vld_s1) begin
				if (ent_v && rdata_s1.key == req_q.key && !found_q) begin
					found_q <= 1'b1;
					midx_q  <= idx_s1;
					ment_q  <= rdata_s1;
				end
				if (ent_v && (!vfound_q || rdata_s1.count < vcount_q)) begin
					vfound_q <= 1'b1;
					vidx_q   <= idx_s1;
					vcount_q <= rdata_s1.count;
					vsize_q  <= rdata_s1.size;
				end
				if (!ent_v && !ffound_q) begin
					ffound_q <= 1'b1;
					fidx_q   <= idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			space_q   <= CAP_RESET;
			valid_q   <= '0;
			nvalid_q  <= '0;
			evicted_q <= '0;
		end else begin
			if (cmd.load) evicted_q <= '0;
			if (cfg_we) begin
				cap_q    <= cfg_wdata;
				space_q  <= cfg_wdata;
				valid_q  <= '0;
				nvalid_q <= '0;
			end else if (cmd.clear_all) begin
				space_q  <= cap_q;
				valid_q  <= '0;
				nvalid_q <= '0;
			end else if (cmd.free_match) begin
				valid_q[midx_q] <= 1'b0;
				space_q         <= space_q + ment_q.size;
				nvalid_q        <= nvalid_q - 1'b1;
			end else if (cmd.free_victim) begin
				valid_q[vidx_q] <= 1'b0;
				space_q         <= space_q + vsize_q;
				nvalid_q        <= nvalid_q - 1'b1;
				evicted_q       <= evicted_q + 1'b1;
			end else if (cmd.place) begin
				valid_q[fidx_q] <= 1'b1;
				space_q         <= space_q - req_q.item_size;
				nvalid_q        <= nvalid_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status        <= cmd.status;
			rsp_q.hit           <= found_q;
			rsp_q.read_value    <= (req_q.op == OP_GET && found_q) ? ment_q.value : '0;
			rsp_q.free_space    <= space_q;
			rsp_q.evicted_count <= evicted_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign sts.op         = req_q.op;
	assign sts.hit        = found_q;
	assign sts.too_large  = (req_q.item_size > cap_q);
	assign sts.need_evict = (space_q < req_q.item_size) || (nvalid_q == FULL_CNT);
	assign sts.any_valid  = (nvalid_q != '0);
	assign sts.scan_done  = vld_s1 && last_s1;
	assign sts.rsp_free   = rsp_free;

endmodule

// ===== rtl/core/lfu_sized_entry_cache.sv =====
// Keyed LFU cache of variable-size entries under a size budget.
// Request channel: req_valid / req_stall carry one req_data (op, key, item_size,
// item_value); a request is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall carry one rsp_data per request, held in
// an output register, so the next request is taken while a response still waits.
// Configuration: cfg_we writes cfg_wdata as the capacity and empties the table;
// write it only while no request is in flight.
// Walks: every request walks the slot table once to find its key, one slot
// per cycle through the slot memory read port. An add that fits the capacity
// walks the table once more to find the lowest free slot, and once more per
// evicted entry (each eviction is a full lowest-count walk). Only one request
// is worked on at a time: a new request is taken only once the last one has
// reached the output register.
// Reset: table empty, capacity and free space 65535, no response pending.
// A stalled response holds in the output register; the controller waits in its
// final state until the register frees, then takes the next request.
module lfu_sized_entry_cache
	import lfu_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp_data,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	// Controller issues one-cycle commands; datapath reports scan and table status.
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Slot memory, valid bits, free-space counter, walk trackers and output register.
	lfu_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== dv/tb_lfu_sized_entry_cache.sv =====
`timescale 1ns / 1ps

module tb_lfu_sized_entry_cache;
	import lfu_pkg::*;

	localparam int SLOTS          = 16;
	localparam int KEY_POOL       = 24;    // small key set so gets, re-adds and removes hit
	localparam int SETTLE_CYCLES  = 8;     // every request answers, so a short settle suffices
	localparam int END_CYCLES     = 400;   // above the worst add: full walk plus 16 evictions
	localparam int LONG_HOLD      = 400;   // one long output hold-off to back up the block
	localparam int LONG_HOLD_AT   = 300;   // response count that triggers it
	localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
	localparam int MAX_PRINTS     = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req_data = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp_data;
	logic              cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	// Shadow copy of the slot table, free space and budget.
	logic               ent_valid [SLOTS];
	logic [KEY_W-1:0]   ent_key   [SLOTS];
	logic [SIZE_W-1:0]  ent_size  [SLOTS];
	logic [VALUE_W-1:0] ent_value [SLOTS];
	logic [COUNT_W-1:0] ent_count [SLOTS];
	logic [SIZE_W-1:0]  cache_space;
	logic [SIZE_W-1:0]  cache_capacity;

	req_t queued_requests[$];
	rsp_t predicted_responses[$];
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	// Idle shaping, switched per phase by the sequence below.
	bit send_gaps_on  = 1'b1;
	bit stall_gaps_on = 1'b1;
	bit long_hold_done = 1'b0;
	int send_gap  = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	int error_count     = 0;
	int requests_taken  = 0;
	int responses_seen  = 0;
	int hits_seen       = 0;
	int misses_seen     = 0;
	int too_large_seen  = 0;
	int evictions_seen  = 0;
	int max_evict_seen  = 0;
	int capacity_writes = 0;

	lfu_sized_entry_cache #(
		.ENTRIES(SLOTS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Cache predictor
	// ------------------------------------------------------------------

	// Drop every entry and hand the whole budget back.
	function automatic void empty_cache();
		for (int i = 0; i < SLOTS; i++) begin
			ent_valid[i] = 1'b0;
		end
		cache_space = cache_capacity;
	endfunction

	// Free one slot; the size returns to the budget (16-bit wrap, as the hardware).
	function automatic void release_entry(input int slot);
		cache_space    = cache_space + ent_size[slot];
		ent_valid[slot] = 1'b0;
	endfunction

	function automatic int first_free_slot();
		for (int i = 0; i < SLOTS; i++) begin
			if (!ent_valid[i])
				return i;
		end
		return -1;
	endfunction

	// Apply one request to the shadow table and return the response it must produce.
	function automatic rsp_t predict_cache_response(input req_t req);
		rsp_t res;
		int   match;
		int   victim;
		int   slot;
		int   evicted;
		bit   searching;

		res       = '0;
		res.status = ST_OK;
		evicted   = 0;
		match     = -1;
		// lowest matching valid slot wins
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (ent_valid[i] && ent_key[i] == req.key)
				match = i;
		end
		res.hit = (match >= 0);

		if (req.op == OP_ADD) begin
			if (req.item_size > cache_capacity) begin
				// oversized add wipes the table, hit still reflects the old contents
				empty_cache();
				res.status = ST_TOO_LARGE;
			end else begin
				// re-add: release the old copy first, not counted as an eviction
				if (match >= 0)
					release_entry(match);
				searching = 1'b1;
				while (searching && (cache_space < req.item_size || first_free_slot() < 0)) begin
					victim = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (ent_valid[i] && (victim < 0 || ent_count[i] < ent_count[victim]))
							victim = i;
					end
					if (victim < 0) begin
						searching = 1'b0;
					end else begin
						release_entry(victim);
						evicted++;
					end
				end
				slot = first_free_slot();
				if (slot >= 0 && cache_space >= req.item_size) begin
					ent_valid[slot] = 1'b1;
					ent_key[slot]   = req.key;
					ent_size[slot]  = req.item_size;
					ent_value[slot] = req.item_value;
					ent_count[slot] = COUNT_NEW;
					cache_space     = cache_space - req.item_size;
				end
			end
		end else if (match < 0) begin
			res.status = ST_NOT_FOUND;
		end else if (req.op == OP_GET) begin
			if (ent_count[match] != COUNT_MAX)
				ent_count[match] = ent_count[match] + 1'b1;
			res.read_value = ent_value[match];
		end else if (req.op == OP_REMOVE) begin
			release_entry(match);
		end

		res.free_space    = cache_space;
		res.evicted_count = evicted[EVICT_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int pick_idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 2);
		else if (roll < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_request(input op_t op, input logic [KEY_W-1:0] key,
		input logic [SIZE_W-1:0] size, input logic [VALUE_W-1:0] value);
		req_t item;
		item.op         = op;
		item.key        = key;
		item.item_size  = size;
		item.item_value = value;
		queued_requests.push_back(item);
	endfunction

	// Random traffic shaped against the current budget: mostly pool keys, sizes that
	// leave room for several entries, some full-budget and some oversized adds.
	task automatic queue_random_requests(input int count);
		req_t item;
		int   roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				item.op = OP_ADD;
			else if (roll < 70)
				item.op = OP_GET;
			else if (roll < 85)
				item.op = OP_EXISTS;
			else
				item.op = OP_REMOVE;
			if ($urandom_range(0, 9) == 0)
				item.key = $urandom;
			else
				item.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
			item.item_value = $urandom;
			roll = $urandom_range(0, 99);
			if (item.op != OP_ADD)
				item.item_size = SIZE_W'($urandom);  // ignored by the block, keep it moving
			else if (roll < 10)
				item.item_size = '0;
			else if (roll < 70)
				item.item_size = SIZE_W'($urandom_range(0, cache_capacity / 8));
			else if (roll < 88)
				item.item_size = SIZE_W'($urandom_range(0, cache_capacity));
			else if (roll < 95 || cache_capacity == CAP_RESET)
				item.item_size = cache_capacity;
			else
				item.item_size = SIZE_W'($urandom_range(32'(cache_capacity) + 1, CAP_RESET));
			queued_requests.push_back(item);
		end
	endtask

	// Hold off the test sequence until every response is in and the block is back to idle.
	task automatic drain_cache();
		while (queued_requests.size() != 0 || req_valid || predicted_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the budget while idle; the block empties its table, so does the shadow.
	task automatic write_capacity(input logic [SIZE_W-1:0] cap);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cache_capacity = cap;
		empty_cache();
		capacity_writes++;
		send_gaps_on  = ($urandom_range(0, 9) < 7);
		stall_gaps_on = ($urandom_range(0, 9) < 7);
	endtask

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Request driver: advance through the queue, hold the request while stalled,
	// predict at the edge that takes it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap  <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				predicted_responses.push_back(predict_cache_response(req_data));
				requests_taken++;
			end
			if (req_valid && req_stall) begin
				// hold the stalled request untouched
			end else if (send_gap != 0) begin
				req_valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (queued_requests.size() != 0) begin
				req_valid <= 1'b1;
				req_data  <= queued_requests.pop_front();
				send_gap  <= (send_gaps_on && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response monitor and stall generator
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				responses_seen++;
				if (predicted_responses.size() == 0) begin
					report_error($sformatf("response with nothing outstanding: %h", rsp_data));
				end else begin
					want = predicted_responses.pop_front();
					if (rsp_data.status != want.status)
						report_error($sformatf("response %0d status %0d, want %0d",
							responses_seen, rsp_data.status, want.status));
					if (rsp_data.hit != want.hit)
						report_error($sformatf("response %0d hit %0d, want %0d",
							responses_seen, rsp_data.hit, want.hit));
					if (rsp_data.read_value != want.read_value)
						report_error($sformatf("response %0d read_value %h, want %h",
							responses_seen, rsp_data.read_value, want.read_value));
					if (rsp_data.free_space != want.free_space)
						report_error($sformatf("response %0d free_space %0d, want %0d",
							responses_seen, rsp_data.free_space, want.free_space));
					if (rsp_data.evicted_count != want.evicted_count)
						report_error($sformatf("response %0d evicted_count %0d, want %0d",
							responses_seen, rsp_data.evicted_count, want.evicted_count));
					hits_seen      += int'(want.hit);
					misses_seen    += int'(want.status == ST_NOT_FOUND);
					too_large_seen += int'(want.status == ST_TOO_LARGE);
					evictions_seen += int'(want.evicted_count);
					if (int'(want.evicted_count) > max_evict_seen)
						max_evict_seen = int'(want.evicted_count);
				end
			end

			// stall: finish a running hold, else maybe start the long one, else random gaps
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && responses_seen >= LONG_HOLD_AT) begin
				long_hold_done <= 1'b1;
				rsp_stall      <= 1'b1;
				hold_left      <= LONG_HOLD - 1;
			end else if (stall_gaps_on && $urandom_range(0, 99) < 25) begin
				rsp_stall <= 1'b1;
				hold_left <= pick_idle_len();
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no request or response moved for %0d cycles, %0d pending",
				$realtime, quiet_cycles, predicted_responses.size());
			$display("tb_lfu_sized_entry_cache: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [KEY_W-1:0] first_key;

		cache_capacity = CAP_RESET;
		empty_cache();
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset budget: misses on an empty table, fill all slots,
		// one add that must evict everything, a re-add and a remove.
		first_key = '0;
		queue_request(OP_GET, first_key, '0, '0);
		queue_request(OP_EXISTS, '1, '1, '1);
		queue_request(OP_REMOVE, first_key, '0, '0);
		queue_request(OP_ADD, first_key, 16'd1, $urandom);
		for (int i = 1; i < SLOTS; i++)
			queue_request(OP_ADD, $urandom, 16'd1, $urandom);
		queue_request(OP_GET, first_key, '0, '0);
		queue_request(OP_EXISTS, first_key, '0, '0);
		queue_request(OP_ADD, '1, CAP_RESET, '1);
		queue_request(OP_GET, '1, '0, '0);
		queue_request(OP_ADD, '1, '0, '0);
		queue_request(OP_REMOVE, '1, '0, '0);
		queue_request(OP_GET, '1, '0, '0);
		queue_random_requests(180);
		drain_cache();

		// Random phases over several budgets, the extremes among them. The long
		// output hold-off lands inside the second phase.
		write_capacity(16'd1000);
		queue_random_requests(250);
		drain_cache();

		write_capacity(16'd1);
		queue_random_requests(80);
		drain_cache();

		write_capacity(16'd0);
		queue_random_requests(20);
		drain_cache();

		write_capacity(16'd300);
		queue_random_requests(220);
		drain_cache();

		write_capacity(CAP_RESET);
		queue_random_requests(200);
		drain_cache();

		write_capacity(SIZE_W'($urandom_range(1, 65535)));
		queue_random_requests(200);
		drain_cache();

		repeat (END_CYCLES) @(posedge clk);

		$display("covered %0d requests over %0d budget settings: %0d hits, %0d misses,",
			requests_taken, capacity_writes + 1, hits_seen, misses_seen);
		$display("%0d oversized adds, %0d evictions (up to %0d in one add), %0d-cycle hold-off",
			too_large_seen, evictions_seen, max_evict_seen, LONG_HOLD);
		if (error_count == 0)
			$display("tb_lfu_sized_entry_cache: PASS");
		else
			$display("tb_lfu_sized_entry_cache: FAIL");
		$finish;
	end

endmodule

// ===== lfu_sized_entry_cache.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dpath.sv
rtl/core/lfu_sized_entry_cache.sv
dv/tb_lfu_sized_entry_cache.sv
